// ===== hw/rtl/pip_pkg.sv =====
// point-in-polygon test: shared types, codes and default sizes
// used by pip_ctrl, pip_dp and point_in_polygon_test
`default_nettype none

package pip_pkg;

  localparam int PIP_MAX_VERTICES = 64;
  localparam int PIP_COORD_BITS   = 24;
  localparam int PIP_INDEX_BITS   = 6;
  localparam int PIP_COUNT_BITS   = 7;
  localparam int PIP_ADDR_BITS    = 3;
  localparam int PIP_DATA_BITS    = 32;

  // register index, taken from paddr[2]
  localparam logic PIP_REG_VERTEX_COUNT = 1'b0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } pip_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } pip_state_t;

  typedef struct packed {
    logic write;
    logic start;
    logic issue;
    logic load_out;
  } pip_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic last_issue;
    logic busy;
    logic out_free;
  } pip_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pip_ctrl.sv =====
// point-in-polygon controller: request handshake and edge walk sequencing
// depends on pip_pkg
`default_nettype none

module pip_ctrl
  import pip_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_op,
  output logic           in_stall,
  input  wire pip_stat_t stat,
  output pip_cmd_t       cmd
);

  pip_state_t state;
  pip_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (pip_op_t'(in_op) == OP_QUERY) begin
            cmd.start  = 1'b1;
            state_next = stat.cnt_zero ? ST_DRAIN : ST_WALK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy && stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pip_dp.sv =====
// point-in-polygon datapath: vertex store, edge pipeline, parity flag, result register
// depends on pip_pkg; driven by pip_ctrl commands
`default_nettype none

module pip_dp
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = PIP_MAX_VERTICES,
  parameter int COORD_BITS   = PIP_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pip_cmd_t                     cmd,
  input  wire logic [PIP_INDEX_BITS-1:0]    vertex_index,
  input  wire logic signed [COORD_BITS-1:0] x_coord,
  input  wire logic signed [COORD_BITS-1:0] y_coord,
  input  wire logic [PIP_COUNT_BITS-1:0]    vertex_count,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic                              inside_res,
  output pip_stat_t                         stat
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic [AW-1:0]                addr;
  logic [AW-1:0]                nlast;
  logic                         first;
  logic                         wr_ok;

  logic                         rd_valid;
  logic                         rd_first;
  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;

  logic                         s2_valid;
  logic                         s2_straddle;
  logic signed [DW-1:0]         dxp;
  logic signed [DW-1:0]         dy;
  logic signed [DW-1:0]         dxe;
  logic signed [DW-1:0]         dyp;

  logic                         s3_valid;
  logic                         s3_straddle;
  logic                         s3_dpos;
  logic signed [PW-1:0]         lhs;
  logic signed [PW-1:0]         rhs;

  logic                         parity;
  logic                         crosses;

  assign wr_ok = cmd.write && (32'(vertex_index) < MAX_VERTICES);

  // vertex store
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_x[AW'(vertex_index)] <= x_coord;
      mem_y[AW'(vertex_index)] <= y_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_x <= mem_x[addr];
      rd_y <= mem_y[addr];
    end
  end

  // walk order: last vertex, then 0 .. n-1
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px    <= x_coord;
      py    <= y_coord;
      first <= 1'b1;
      if (32'(vertex_count) >= MAX_VERTICES) begin
        nlast <= AW'(MAX_VERTICES - 1);
        addr  <= AW'(MAX_VERTICES - 1);
      end else begin
        nlast <= AW'(vertex_count - PIP_COUNT_BITS'(1));
        addr  <= AW'(vertex_count - PIP_COUNT_BITS'(1));
      end
    end else if (cmd.issue) begin
      first <= 1'b0;
      addr  <= first ? '0 : addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      s2_valid <= rd_valid && !rd_first;
      s3_valid <= s2_valid;
    end
  end

  // edge differences: a is the current vertex, b the one before it
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_first <= first;
    end
    if (rd_valid) begin
      prev_x      <= rd_x;
      prev_y      <= rd_y;
      dxp         <= DW'(px) - DW'(rd_x);
      dy          <= DW'(prev_y) - DW'(rd_y);
      dxe         <= DW'(prev_x) - DW'(rd_x);
      dyp         <= DW'(py) - DW'(rd_y);
      s2_straddle <= (rd_y > py) != (prev_y > py);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      lhs         <= PW'(dxp) * PW'(dy);
      rhs         <= PW'(dxe) * PW'(dyp);
      s3_dpos     <= !dy[DW-1];
      s3_straddle <= s2_straddle;
    end
  end

  assign crosses = s3_straddle && (s3_dpos ? (lhs < rhs) : (lhs > rhs));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      parity <= 1'b0;
    end else if (s3_valid && crosses) begin
      parity <= !parity;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      inside_res <= parity;
    end
  end

  always_comb begin
    stat.cnt_zero   = (vertex_count == '0);
    stat.last_issue = !first && (addr == nlast);
    stat.busy       = rd_valid || s2_valid || s3_valid;
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/point_in_polygon_test.sv =====
// point-in-polygon test, top level: register port, controller and datapath
// depends on pip_pkg, pip_ctrl, pip_dp
// a vertex write is taken without leaving idle; a query walks one edge per cycle through the single
// read port of the vertex store, n + 1 reads for n vertices in use (n = vertex_count,
// saturated to MAX_VERTICES), and its result is loaded once the edge pipeline has drained;
// the next request is taken only after that (with no walk when n is zero), and later
// while a waiting result is held by out_stall
// reset clears the controller, pipeline valids and vertex_count; the vertex store is kept
`default_nettype none

module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = PIP_MAX_VERTICES,
  parameter int COORD_BITS   = PIP_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         op,
  input  wire logic [PIP_INDEX_BITS-1:0]    vertex_index,
  input  wire logic signed [COORD_BITS-1:0] x_coord,
  input  wire logic signed [COORD_BITS-1:0] y_coord,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              inside_res,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [PIP_ADDR_BITS-1:0]     paddr,
  input  wire logic [PIP_DATA_BITS-1:0]     pwdata,
  output logic [PIP_DATA_BITS-1:0]          prdata,
  output logic                              pready
);

  logic [PIP_COUNT_BITS-1:0] vertex_count;
  pip_cmd_t                  cmd;
  pip_stat_t                 stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == PIP_REG_VERTEX_COUNT)) begin
      vertex_count <= pwdata[PIP_COUNT_BITS-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == PIP_REG_VERTEX_COUNT) begin
      prdata = {(PIP_DATA_BITS - PIP_COUNT_BITS)'(0), vertex_count};
    end else begin
      prdata = '0;
    end
  end

  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pip_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .vertex_index (vertex_index),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .vertex_count (vertex_count),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .inside_res   (inside_res),
    .stat         (stat)
  );

endmodule

`default_nettype wire

// ===== test/point_in_polygon_test_tb.sv =====
// testbench for point_in_polygon_test: vertex writes and point queries with random
// idling on both sides, checked against an even-odd ray-casting predictor
// depends on pip_pkg and point_in_polygon_test
`timescale 1ns / 1ps

module point_in_polygon_test_tb;
  import pip_pkg::*;

  typedef logic signed [PIP_COORD_BITS-1:0] coord_t;

  typedef struct packed {
    pip_op_t                   op;
    logic [PIP_INDEX_BITS-1:0] idx;
    coord_t                    x;
    coord_t                    y;
    int                        want;
  } pip_req_t;

  typedef struct packed {
    int                        new_count;
    pip_op_t                   op;
    logic [PIP_INDEX_BITS-1:0] idx;
    coord_t                    x;
    coord_t                    y;
    int                        want;
  } dir_row_t;

  localparam int NO_CHANGE   = -1;
  localparam int PREDICT     = -1;
  localparam int RAND_ITEMS  = 500;
  localparam int SETTLE      = PIP_MAX_VERTICES + 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam coord_t C_MIN = {1'b1, {(PIP_COORD_BITS-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(PIP_COORD_BITS-1){1'b1}}};
  localparam logic [PIP_ADDR_BITS-1:0] VC_ADDR = {PIP_REG_VERTEX_COUNT, 2'b00};

  logic                      clk;
  logic                      rst;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      op = OP_WRITE;
  logic [PIP_INDEX_BITS-1:0] vertex_index = '0;
  coord_t                    x_coord = '0;
  coord_t                    y_coord = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      inside_res;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PIP_ADDR_BITS-1:0]  paddr = '0;
  logic [PIP_DATA_BITS-1:0]  pwdata = '0;
  logic [PIP_DATA_BITS-1:0]  prdata;
  logic                      pready;

  point_in_polygon_test dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .vertex_index(vertex_index), .x_coord(x_coord), .y_coord(y_coord),
    .out_valid(out_valid), .out_stall(out_stall), .inside_res(inside_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  coord_t                    vtx_x [PIP_MAX_VERTICES] = '{default: '0};
  coord_t                    vtx_y [PIP_MAX_VERTICES] = '{default: '0};
  logic [PIP_COUNT_BITS-1:0] model_count = '0;
  bit                        vtx_known [PIP_MAX_VERTICES];

  pip_req_t req_queue [$];
  logic     pending_inside [$];
  pip_req_t cur_req;
  logic     exp_bit;
  logic     got_want;
  int       queued_reqs = 0;
  int       posted = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  bit       idle_off = 1'b0;
  int       errors = 0;
  int       n_writes = 0;
  int       n_queries = 0;
  int       n_results = 0;
  int       n_cfg = 0;
  int       cycle_cnt = 0;

  dir_row_t dir_rows [20] = '{
    '{NO_CHANGE, OP_QUERY, 6'd0,  24'sd0, 24'sd0, 0},
    '{NO_CHANGE, OP_QUERY, 6'd63, C_MIN,  C_MAX,  0},
    '{NO_CHANGE, OP_WRITE, 6'd0,  C_MIN,  C_MIN,  PREDICT},
    '{NO_CHANGE, OP_WRITE, 6'd1,  C_MAX,  C_MIN,  PREDICT},
    '{NO_CHANGE, OP_WRITE, 6'd2,  C_MAX,  C_MAX,  PREDICT},
    '{NO_CHANGE, OP_WRITE, 6'd3,  C_MIN,  C_MAX,  PREDICT},
    '{1,         OP_QUERY, 6'd0,  24'sd0, 24'sd0, 0},
    '{NO_CHANGE, OP_QUERY, 6'd0,  C_MIN,  C_MIN,  0},
    '{2,         OP_QUERY, 6'd0,  24'sd0, 24'sd0, PREDICT},
    '{4,         OP_QUERY, 6'd0,  24'sd0, 24'sd0, PREDICT},
    '{NO_CHANGE, OP_QUERY, 6'd0,  C_MIN,  24'sd0, PREDICT},
    '{NO_CHANGE, OP_QUERY, 6'd0,  C_MAX,  24'sd0, PREDICT},
    '{NO_CHANGE, OP_QUERY, 6'd0,  24'sd0, C_MIN,  PREDICT},
    '{NO_CHANGE, OP_QUERY, 6'd0,  24'sd0, C_MAX,  PREDICT},
    '{NO_CHANGE, OP_QUERY, 6'd0,  C_MIN,  C_MIN,  PREDICT},
    '{NO_CHANGE, OP_QUERY, 6'd0,  C_MAX,  C_MAX,  PREDICT},
    '{NO_CHANGE, OP_WRITE, 6'd63, 24'sd5, -24'sd5, PREDICT},
    '{3,         OP_QUERY, 6'd0,  24'sd1000, -24'sd1000, PREDICT},
    '{NO_CHANGE, OP_QUERY, 6'd0,  -24'sd1000, 24'sd1000, PREDICT},
    '{0,         OP_QUERY, 6'd0,  24'sd7, 24'sd7, 0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d requests still queued, %0d results outstanding",
             $realtime, queued_reqs, pending_inside.size());
    $display("FAILURE");
    $finish;
  end

  // even-odd ray cast with exact cross-multiplication
  function automatic logic ray_cast_inside(input coord_t px, input coord_t py);
    int     n;
    int     j;
    logic   flag;
    longint pxl, pyl, xa, ya, xb, yb, d, lhs, rhs;
    flag = 1'b0;
    pxl  = longint'(px);
    pyl  = longint'(py);
    n    = (model_count > PIP_MAX_VERTICES) ? PIP_MAX_VERTICES : int'(model_count);
    for (int i = 0; i < n; i++) begin
      j  = (i == 0) ? n - 1 : i - 1;
      xa = longint'(vtx_x[i]);
      ya = longint'(vtx_y[i]);
      xb = longint'(vtx_x[j]);
      yb = longint'(vtx_y[j]);
      if ((ya > pyl) != (yb > pyl)) begin
        d   = yb - ya;
        lhs = (pxl - xa) * d;
        rhs = (xb - xa) * (pyl - ya);
        if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) flag = ~flag;
      end
    end
    return flag;
  endfunction

  // request driver, predictor updated on each accepted request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        queued_reqs--;
        if (cur_req.op == OP_WRITE) begin
          if (cur_req.idx < PIP_MAX_VERTICES) begin
            vtx_x[cur_req.idx] = cur_req.x;
            vtx_y[cur_req.idx] = cur_req.y;
          end
          n_writes++;
        end else begin
          exp_bit = ray_cast_inside(cur_req.x, cur_req.y);
          if (cur_req.want >= 0) exp_bit = cur_req.want[0];
          pending_inside = {pending_inside, exp_bit};
          n_queries++;
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_queue.size() > 0) begin
        cur_req = req_queue.pop_front();
        op           <= cur_req.op;
        vertex_index <= cur_req.idx;
        x_coord      <= cur_req.x;
        y_coord      <= cur_req.y;
        in_valid     <= 1'b1;
        if (!idle_off && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_inside.size() == 0) begin
          $display("%0t: inside_res %0d with no query outstanding", $realtime, inside_res);
          errors++;
        end else begin
          got_want = pending_inside.pop_front();
          if (inside_res !== got_want) begin
            $display("%0t: inside_res mismatch, expected %0d got %0d",
                     $realtime, got_want, inside_res);
            errors++;
          end
        end
      end
      if (stall_left > 0 && !idle_off) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = 0;
        if (!idle_off && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  task automatic post_req(input pip_op_t o, input logic [PIP_INDEX_BITS-1:0] idx,
                          input coord_t x, input coord_t y, input int want);
    pip_req_t r;
    r.op   = o;
    r.idx  = idx;
    r.x    = x;
    r.y    = y;
    r.want = want;
    if (o == OP_WRITE) vtx_known[idx] = 1'b1;
    queued_reqs++;
    posted++;
    req_queue = {req_queue, r};
  endtask

  task automatic wait_idle();
    while (queued_reqs != 0 || pending_inside.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic [PIP_DATA_BITS-1:0] wdata,
                           output logic [PIP_DATA_BITS-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= VC_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_vertex_count(input int value);
    logic [PIP_COUNT_BITS-1:0] word;
    logic [PIP_DATA_BITS-1:0]  rd;
    word = value[PIP_COUNT_BITS-1:0];
    wait_idle();
    apb_cycle(1'b1, PIP_DATA_BITS'(word), rd);
    apb_cycle(1'b0, '0, rd);
    if (rd[PIP_COUNT_BITS-1:0] !== word) begin
      $display("%0t: vertex_count readback mismatch, expected %0d got %0d",
               $realtime, word, rd[PIP_COUNT_BITS-1:0]);
      errors++;
    end
    model_count = word;
    n_cfg++;
  endtask

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'(int'($urandom_range(0, 32)) - 16);
      2: begin
        case ($urandom_range(0, 4))
          0: return C_MIN;
          1: return C_MAX;
          2: return coord_t'(0);
          3: return coord_t'(-1);
          default: return coord_t'(1);
        endcase
      end
      default: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  initial begin
    int cnt, n_eff, mode, r, n_q, ph;
    coord_t qx, qy;
    ph = 0;
    @(negedge rst);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].new_count != NO_CHANGE) set_vertex_count(dir_rows[k].new_count);
      post_req(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].x, dir_rows[k].y,
               dir_rows[k].want);
    end

    while (posted < RAND_ITEMS + $size(dir_rows)) begin
      if (ph == 0) cnt = 127;
      else if (ph == 1) cnt = PIP_MAX_VERTICES;
      else begin
        r = $urandom_range(0, 24);
        if (r == 0) cnt = 0;
        else if (r == 1) cnt = 1;
        else if (r == 2) cnt = 2;
        else if (r == 3) cnt = $urandom_range(65, 127);
        else if (r == 4) cnt = $urandom_range(17, 64);
        else cnt = $urandom_range(3, 12);
      end
      ph++;
      n_eff = (cnt > PIP_MAX_VERTICES) ? PIP_MAX_VERTICES : cnt;
      mode  = $urandom_range(0, 3);
      set_vertex_count(cnt);
      idle_off = (posted > RAND_ITEMS + $size(dir_rows) - 100) || ($urandom_range(0, 3) == 0);

      // polygon outline first, so that no query reads an unwritten vertex
      for (int i = 0; i < n_eff; i++)
        if (!vtx_known[i] || n_eff <= 16 || $urandom_range(0, 7) == 0)
          post_req(OP_WRITE, PIP_INDEX_BITS'(i), rand_coord(mode), rand_coord(mode), PREDICT);

      n_q = (n_eff > 16) ? $urandom_range(4, 8) : $urandom_range(6, 20);
      for (int q = 0; q < n_q; q++) begin
        if ($urandom_range(0, 5) == 0)
          post_req(OP_WRITE, PIP_INDEX_BITS'($urandom()), rand_coord(mode), rand_coord(mode),
                   PREDICT);
        qx = (n_eff > 0 && $urandom_range(0, 3) == 0) ?
             vtx_x[$urandom_range(0, n_eff - 1)] : rand_coord(mode);
        qy = (n_eff > 0 && $urandom_range(0, 3) == 0) ?
             vtx_y[$urandom_range(0, n_eff - 1)] : rand_coord(mode);
        post_req(OP_QUERY, PIP_INDEX_BITS'($urandom()), qx, qy, PREDICT);
      end
    end

    wait_idle();
    $display("covered %0d requests: %0d vertex writes, %0d queries, %0d vertex_count settings",
             n_writes + n_queries, n_writes, n_queries, n_cfg);
    $display("%0d results checked, %0d errors", n_results, errors);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pip_pkg.sv
hw/rtl/pip_ctrl.sv
hw/rtl/pip_dp.sv
hw/rtl/point_in_polygon_test.sv
test/point_in_polygon_test_tb.sv
